FILE: src/tristate_remote_pulse_encoder_core_assert.svh
// Assertion macros shared by the tri-state remote pulse encoder RTL.
`ifndef TRISTATE_REMOTE_PULSE_ENCODER_CORE_ASSERT_SVH
`define TRISTATE_REMOTE_PULSE_ENCODER_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define TRPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define TRPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/trpe_pkg.sv
// Package with the constants, codes and helper function of the tri-state remote pulse encoder.
package trpe_pkg;

    // Address and code word geometry.
    localparam int ADDRESS_WIDTH = 10;
    localparam int WORD_BITS     = 2 * ADDRESS_WIDTH + 6;
    // Every data symbol and the sync symbol have a high and a low phase.
    localparam int PHASES        = 2 * (WORD_BITS + 1);
    localparam int PHASE_W       = $clog2(PHASES);
    localparam int SEARCH_W      = $clog2(PHASES + 1);

    // Field widths.
    localparam int UNIT_W    = 8;
    localparam int PULSE_W   = 16;
    localparam int REPEAT_W  = 8;
    localparam int TICK_W    = 24;
    localparam int CFG_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 8;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_HIGH     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_LOW      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_HIGH    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_LOW     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_HIGH    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_LOW     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_UNIT   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_COUNT = 3'd7;

    // Phase kinds; each selects one unit count register.
    localparam int NUM_KINDS = 6;
    localparam int KIND_W    = 3;
    localparam logic [KIND_W-1:0] KIND_ONE_HIGH  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ONE_LOW   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ZERO_HIGH = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ZERO_LOW  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SYNC_HIGH = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SYNC_LOW  = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [UNIT_W-1:0]   RST_ONE_HIGH     = 8'd3;
    localparam logic [UNIT_W-1:0]   RST_ONE_LOW      = 8'd1;
    localparam logic [UNIT_W-1:0]   RST_ZERO_HIGH    = 8'd1;
    localparam logic [UNIT_W-1:0]   RST_ZERO_LOW     = 8'd3;
    localparam logic [UNIT_W-1:0]   RST_SYNC_HIGH    = 8'd1;
    localparam logic [UNIT_W-1:0]   RST_SYNC_LOW     = 8'd31;
    localparam logic [PULSE_W-1:0]  RST_PULSE_UNIT   = 16'd350;
    localparam logic [REPEAT_W-1:0] RST_REPEAT_COUNT = 8'd10;

    // On/off symbol pairs.
    localparam logic [3:0] SYM_ON  = 4'b0001;
    localparam logic [3:0] SYM_OFF = 4'b0100;

    // Mode codes carried in tuser.
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    // One result word.
    typedef struct packed {
        logic busy;
        logic pin;
    } trpe_result_t;

    // Builds the code word, first address character in the most significant pair.
    function automatic logic [WORD_BITS-1:0] build_code_word(
        input logic [ADDRESS_WIDTH-1:0] addr,
        input logic                     on
    );
        logic [WORD_BITS-1:0] w;
        w = '0;
        for (int i = 0; i < ADDRESS_WIDTH; i++) begin
            w[WORD_BITS-1-2*i] = 1'b0;
            w[WORD_BITS-2-2*i] = ~addr[ADDRESS_WIDTH-1-i];
        end
        w[5:2] = on ? SYM_ON : SYM_OFF;
        w[1:0] = 2'b00;
        return w;
    endfunction

endpackage

FILE: src/tristate_remote_pulse_encoder_core.sv
// Tri-state remote pulse encoder: code word builder, phase sequencer and result skid stage.
//
// Channel  | Direction | Payload
// ---------+-----------+-------------------------------------------------------
// s_       | in        | tuser: mode; tdata: address_bits[9:0], power_on[10]
// m_       | out       | tdata: pin_level[0], busy_res[1]
// cfg_     | in        | write enable, register index, 16-bit write data
//
// A new word is accepted each cycle while the skid stage is empty.
// Phases of zero length are skipped in the same cycle by a priority search over the
// phase mask of the frame; phase lengths are the six unit-count products, formed each cycle.
// A stalled result waits in the output register and a second one in the skid register;
// s_tready falls only while both are full.
// Reset (aresetn low, synchronous) restores the register defaults and leaves the block idle.
`include "tristate_remote_pulse_encoder_core_assert.svh"

module tristate_remote_pulse_encoder_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input words.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [trpe_pkg::S_DATA_W-1:0]    s_tdata,  // address_bits[9:0], power_on[10], zeros
    input  logic                             s_tuser,  // mode: 0 tick, 1 start
    // Result words.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [trpe_pkg::M_DATA_W-1:0]    m_tdata,  // pin_level[0], busy_res[1], zeros
    // Configuration writes.
    input  logic                             cfg_we,
    input  logic [trpe_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [trpe_pkg::CFG_W-1:0]       cfg_wdata
);
    import trpe_pkg::*;

    // Configuration registers.
    logic [UNIT_W-1:0]   units_reg [NUM_KINDS];
    logic [PULSE_W-1:0]  pulse_unit_reg;
    logic [REPEAT_W-1:0] repeat_count_reg;

    // Phase lengths in ticks, one per kind.
    logic [TICK_W-1:0]   phase_len [NUM_KINDS];

    // Transmission state.
    logic [WORD_BITS-1:0] code_word_reg, code_word_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [REPEAT_W-1:0]  repeats_reg, repeats_next;
    logic [TICK_W-1:0]    rem_reg, rem_next;
    logic                 sending_reg, sending_next;

    // Output stage.
    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    trpe_result_t out_data_reg, out_data_next;
    trpe_result_t skid_data_reg, skid_data_next;

    // Search signals.
    logic [KIND_W-1:0]   phase_kind [PHASES];
    logic [PHASES-1:0]   phase_mask;
    logic [NUM_KINDS-1:0] unit_nz;
    logic [SEARCH_W-1:0] search_start;
    logic                from_found, any_found;
    logic [PHASE_W-1:0]  from_idx, any_idx;
    logic [KIND_W-1:0]   from_kind, any_kind;

    logic         s_fire, m_take;
    logic         out_pin_ok;
    trpe_result_t res;

    assign s_fire   = s_tvalid && s_tready;
    assign m_take   = m_tvalid && m_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-2){1'b0}}, out_data_reg.busy, out_data_reg.pin};

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            units_reg[KIND_ONE_HIGH]  <= RST_ONE_HIGH;
            units_reg[KIND_ONE_LOW]   <= RST_ONE_LOW;
            units_reg[KIND_ZERO_HIGH] <= RST_ZERO_HIGH;
            units_reg[KIND_ZERO_LOW]  <= RST_ZERO_LOW;
            units_reg[KIND_SYNC_HIGH] <= RST_SYNC_HIGH;
            units_reg[KIND_SYNC_LOW]  <= RST_SYNC_LOW;
            pulse_unit_reg            <= RST_PULSE_UNIT;
            repeat_count_reg          <= RST_REPEAT_COUNT;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_ONE_HIGH:     units_reg[KIND_ONE_HIGH]  <= cfg_wdata[UNIT_W-1:0];
                REG_ONE_LOW:      units_reg[KIND_ONE_LOW]   <= cfg_wdata[UNIT_W-1:0];
                REG_ZERO_HIGH:    units_reg[KIND_ZERO_HIGH] <= cfg_wdata[UNIT_W-1:0];
                REG_ZERO_LOW:     units_reg[KIND_ZERO_LOW]  <= cfg_wdata[UNIT_W-1:0];
                REG_SYNC_HIGH:    units_reg[KIND_SYNC_HIGH] <= cfg_wdata[UNIT_W-1:0];
                REG_SYNC_LOW:     units_reg[KIND_SYNC_LOW]  <= cfg_wdata[UNIT_W-1:0];
                REG_PULSE_UNIT:   pulse_unit_reg            <= cfg_wdata[PULSE_W-1:0];
                REG_REPEAT_COUNT: repeat_count_reg          <= cfg_wdata[REPEAT_W-1:0];
                default: ;
            endcase
        end
    end

    // Phase lengths follow the registers in the same cycle; 8 by 16 bits never exceeds 24 bits.
    always_comb begin
        for (int k = 0; k < NUM_KINDS; k++) begin
            phase_len[k] = TICK_W'(units_reg[k]) * TICK_W'(pulse_unit_reg);
        end
    end

    // A kind has length only if its unit count and the pulse unit are both non-zero.
    always_comb begin
        for (int k = 0; k < NUM_KINDS; k++) begin
            unit_nz[k] = (units_reg[k] != '0) && (pulse_unit_reg != '0);
        end
    end

    // Kind of every phase of the frame, and whether it takes time.
    for (genvar g = 0; g < PHASES; g++) begin : g_phase
        if ((g / 2) == WORD_BITS) begin : g_sync
            assign phase_kind[g] = (g % 2 == 1) ? KIND_SYNC_LOW : KIND_SYNC_HIGH;
        end else begin : g_data
            logic bit_val;
            assign bit_val = code_word_reg[WORD_BITS-1-(g/2)];
            assign phase_kind[g] = bit_val ?
                ((g % 2 == 1) ? KIND_ONE_LOW : KIND_ONE_HIGH) :
                ((g % 2 == 1) ? KIND_ZERO_LOW : KIND_ZERO_HIGH);
        end
        assign phase_mask[g] = unit_nz[phase_kind[g]];
    end

    // First phase with length after the current one, and first in the whole frame.
    assign search_start = SEARCH_W'(phase_reg) + 1'b1;

    always_comb begin
        from_found = 1'b0;
        from_idx   = '0;
        from_kind  = KIND_ONE_HIGH;
        any_found  = 1'b0;
        any_idx    = '0;
        any_kind   = KIND_ONE_HIGH;
        for (int q = PHASES - 1; q >= 0; q--) begin
            if (phase_mask[q]) begin
                any_found = 1'b1;
                any_idx   = PHASE_W'(q);
                any_kind  = phase_kind[q];
                if (SEARCH_W'(q) >= search_start) begin
                    from_found = 1'b1;
                    from_idx   = PHASE_W'(q);
                    from_kind  = phase_kind[q];
                end
            end
        end
    end

    // Next transmission state and the result of the accepted word.
    always_comb begin
        code_word_next = code_word_reg;
        phase_next     = phase_reg;
        repeats_next   = repeats_reg;
        rem_next       = rem_reg;
        sending_next   = sending_reg;
        res.pin        = 1'b0;
        res.busy       = sending_reg;
        if (s_fire) begin
            if (s_tuser == MODE_START) begin
                // A start while busy, or with no repeats, changes nothing.
                if (!sending_reg && repeat_count_reg != '0) begin
                    code_word_next = build_code_word(s_tdata[ADDRESS_WIDTH-1:0],
                                                     s_tdata[ADDRESS_WIDTH]);
                    repeats_next   = repeat_count_reg;
                    phase_next     = '0;
                    // Every code word opens with a zero bit, so its high phase is loaded now.
                    rem_next       = phase_len[KIND_ZERO_HIGH];
                    sending_next   = 1'b1;
                end
                res.busy = sending_next;
            end else if (sending_reg) begin
                res.busy = 1'b1;
                if (rem_reg != '0) begin
                    // Current phase goes on.
                    res.pin  = ~phase_reg[0];
                    rem_next = rem_reg - 1'b1;
                end else if (from_found) begin
                    // Next phase with length in this frame.
                    phase_next = from_idx;
                    rem_next   = phase_len[from_kind] - 1'b1;
                    res.pin    = ~from_idx[0];
                end else if (any_found && repeats_reg != REPEAT_W'(1)) begin
                    // Wrap into the next repeat of the frame.
                    repeats_next = repeats_reg - 1'b1;
                    phase_next   = any_idx;
                    rem_next     = phase_len[any_kind] - 1'b1;
                    res.pin      = ~any_idx[0];
                end else begin
                    // Nothing with length is left: the transmission ends on this tick.
                    sending_next = 1'b0;
                    phase_next   = '0;
                    rem_next     = '0;
                    res.busy     = 1'b0;
                end
            end
        end
    end

    // Output register with a skid register behind it.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_take) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = s_fire;
                out_data_next  = res;
            end
        end else if (s_fire) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    // Control and payload registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_word_reg  <= '0;
            phase_reg      <= '0;
            repeats_reg    <= '0;
            rem_reg        <= '0;
            sending_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            code_word_reg  <= code_word_next;
            phase_reg      <= phase_next;
            repeats_reg    <= repeats_next;
            rem_reg        <= rem_next;
            sending_reg    <= sending_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // A valid result word never shows the pin high without busy.
    assign out_pin_ok = !out_valid_reg || !out_data_reg.pin || out_data_reg.busy;

    // Checks on the sequencer and the output stage.
    `TRPE_ASSERT(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid full with output empty")
    `TRPE_ASSERT(a_phase_range, !sending_reg || (phase_reg < PHASE_W'(PHASES)), "phase out of range")
    `TRPE_ASSERT(a_pin_needs_busy, out_pin_ok, "pin high while not busy")
    `TRPE_ASSERT_NEXT(a_fire_fills_out, s_fire && !out_valid_reg, out_valid_reg, "word lost")

endmodule

FILE: tb/trpe_pin_checker.sv
`timescale 1ns / 100ps
// Checker for the tri-state remote pulse encoder: predicts and compares every result word.
module trpe_pin_checker
    import trpe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // address_bits[9:0], power_on[10], zeros
    input  logic                  s_tuser,   // mode
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,   // pin_level[0], busy_res[1], zeros
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  wrap_up,
    output int                    fail_count
);

    localparam int MAX_REPORTS = 40;

    // Local copy of the timing registers.
    logic [UNIT_W-1:0]   one_high, one_low, zero_high, zero_low, sync_high, sync_low;
    logic [PULSE_W-1:0]  pulse_unit;
    logic [REPEAT_W-1:0] repeat_count;

    // Transmitter state: symbol position runs past the data symbols into the sync symbol.
    logic [WORD_BITS-1:0]            code_word;
    logic [$clog2(WORD_BITS+2)-1:0]  bit_pos;
    logic [REPEAT_W-1:0]             repeats_left;
    logic                            high_phase;
    logic [TICK_W-1:0]               ticks_left;
    logic                            sending;

    // Pin and busy levels still owed by the block, oldest first.
    trpe_result_t expected_levels[$];

    initial fail_count = 0;

    task automatic flag_failure(input string what);
        if (fail_count < MAX_REPORTS)
            $display("%0t ns: %s", $time, what);
        fail_count++;
    endtask

    // Length in ticks of the phase that the state points at.
    function automatic logic [TICK_W-1:0] phase_length();
        logic [UNIT_W-1:0] units;
        logic [TICK_W-1:0] prod;
        if (bit_pos >= WORD_BITS)
            units = high_phase ? sync_high : sync_low;
        else if (code_word[WORD_BITS-1-bit_pos])
            units = high_phase ? one_high : one_low;
        else
            units = high_phase ? zero_high : zero_low;
        prod = TICK_W'(units) * TICK_W'(pulse_unit);
        return prod;
    endfunction

    // Moves on to the next phase; after the last sync of the last frame the send ends.
    function automatic void step_phase();
        if (high_phase) begin
            high_phase = 1'b0;
        end else begin
            bit_pos = bit_pos + 1'b1;
            if (bit_pos > WORD_BITS) begin
                repeats_left = repeats_left - 1'b1;
                bit_pos = '0;
                if (repeats_left == '0) begin
                    sending = 1'b0;
                    ticks_left = '0;
                    return;
                end
            end
            high_phase = 1'b1;
        end
        ticks_left = phase_length();
    endfunction

    // Works out the result of one input word and updates the state.
    function automatic trpe_result_t encode_step(
        input logic                     mode,
        input logic [ADDRESS_WIDTH-1:0] addr,
        input logic                     on
    );
        trpe_result_t         r;
        logic [WORD_BITS-1:0] w;
        r = '0;
        if (mode == MODE_START) begin
            // A start while a send is running, or with no repeats, changes nothing.
            if (!sending && repeat_count != '0) begin
                w = '0;
                for (int i = ADDRESS_WIDTH - 1; i >= 0; i--)
                    w = {w[WORD_BITS-3:0], 1'b0, ~addr[i]};
                w = {w[WORD_BITS-5:0], (on ? SYM_ON : SYM_OFF)};
                w = {w[WORD_BITS-3:0], 2'b00};
                code_word    = w;
                repeats_left = repeat_count;
                bit_pos      = '0;
                high_phase   = 1'b1;
                sending      = 1'b1;
                ticks_left   = phase_length();
            end
            r.busy = sending;
        end else if (sending) begin
            // Phases of zero length cost no tick.
            while (sending && ticks_left == '0)
                step_phase();
            if (sending) begin
                r.pin      = high_phase;
                r.busy     = 1'b1;
                ticks_left = ticks_left - 1'b1;
            end
        end
        return r;
    endfunction

    // Watch all three ports at every edge.
    always @(posedge aclk) begin
        trpe_result_t got, want;
        if (!aresetn) begin
            one_high     = RST_ONE_HIGH;
            one_low      = RST_ONE_LOW;
            zero_high    = RST_ZERO_HIGH;
            zero_low     = RST_ZERO_LOW;
            sync_high    = RST_SYNC_HIGH;
            sync_low     = RST_SYNC_LOW;
            pulse_unit   = RST_PULSE_UNIT;
            repeat_count = RST_REPEAT_COUNT;
            code_word    = '0;
            bit_pos      = '0;
            repeats_left = '0;
            high_phase   = 1'b0;
            ticks_left   = '0;
            sending      = 1'b0;
            expected_levels.delete();
        end else begin
            // A word taken at this edge still sees the registers as they were before it.
            if (s_tvalid && s_tready)
                expected_levels.push_back(encode_step(s_tuser, s_tdata[ADDRESS_WIDTH-1:0],
                                                      s_tdata[ADDRESS_WIDTH]));
            if (cfg_we) begin
                case (cfg_addr)
                    REG_ONE_HIGH:     one_high     = cfg_wdata[UNIT_W-1:0];
                    REG_ONE_LOW:      one_low      = cfg_wdata[UNIT_W-1:0];
                    REG_ZERO_HIGH:    zero_high    = cfg_wdata[UNIT_W-1:0];
                    REG_ZERO_LOW:     zero_low     = cfg_wdata[UNIT_W-1:0];
                    REG_SYNC_HIGH:    sync_high    = cfg_wdata[UNIT_W-1:0];
                    REG_SYNC_LOW:     sync_low     = cfg_wdata[UNIT_W-1:0];
                    REG_PULSE_UNIT:   pulse_unit   = cfg_wdata[PULSE_W-1:0];
                    REG_REPEAT_COUNT: repeat_count = cfg_wdata[REPEAT_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[1:0];
                if (expected_levels.size() == 0) begin
                    flag_failure($sformatf("unexpected result word, pin %0d busy %0d",
                                           got.pin, got.busy));
                end else begin
                    want = expected_levels.pop_front();
                    if (got.pin !== want.pin)
                        flag_failure($sformatf("pin_level mismatch, expected %0d, got %0d",
                                               want.pin, got.pin));
                    if (got.busy !== want.busy)
                        flag_failure($sformatf("busy_res mismatch, expected %0d, got %0d",
                                               want.busy, got.busy));
                end
            end
        end
    end

    // Anything still owed at the end never arrived.
    always @(posedge wrap_up) begin
        if (expected_levels.size() != 0)
            flag_failure($sformatf("%0d result words never arrived", expected_levels.size()));
    end

endmodule

FILE: tb/tristate_remote_pulse_encoder_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the tri-state remote pulse encoder: stimulus, flow control and verdict.
module tristate_remote_pulse_encoder_core_tb;
    import trpe_pkg::*;

    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_CYCLES     = 150;
    localparam int RANDOM_PHASES   = 5;
    localparam int WORDS_PER_PHASE = 40;
    localparam int HOLD_PHASE      = 2;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // address_bits[9:0], power_on[10], zeros
    logic                  s_tuser;   // mode: 0 tick, 1 start
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // pin_level[0], busy_res[1], zeros
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  wrap_up;
    int                    fail_count;

    // Flow control state shared by the two sides.
    bit idling       = 1'b1;
    bit hold_request = 1'b0;
    bit offering     = 1'b0;
    bit last_busy    = 1'b0;
    int words_sent   = 0;
    int results_seen = 0;
    int starts_sent  = 0;
    int settings_loaded = 0;
    int holds_done   = 0;

    always #4 aclk = ~aclk;

    tristate_remote_pulse_encoder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    trpe_pin_checker checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .wrap_up   (wrap_up),
        .fail_count(fail_count)
    );

    // Drops s_tvalid once, only if a word is still on offer.
    task automatic stop_offering();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Offers one word, after a random gap while idling, and waits for it to be taken.
    task automatic send_word(
        input logic                     mode,
        input logic [ADDRESS_WIDTH-1:0] addr,
        input logic                     on
    );
        int gap;
        gap = idling ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            stop_offering();
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(S_DATA_W-ADDRESS_WIDTH-1){1'b0}}, on, addr};
        offering = 1'b1;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (mode == MODE_START)
            starts_sent++;
    endtask

    task automatic send_tick();
        send_word(MODE_TICK, ADDRESS_WIDTH'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_for_results();
        stop_offering();
        while (results_seen != words_sent) @(posedge aclk);
    endtask

    // Ticks the running send through to its end.
    task automatic run_out(input bit fast);
        bit saved;
        saved = idling;
        if (fast)
            idling = 1'b0;
        wait_for_results();
        while (last_busy) begin
            repeat (16) send_tick();
            wait_for_results();
        end
        idling = saved;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Writes the whole register set once the block has gone quiet.
    task automatic load_settings(
        input logic [UNIT_W-1:0]   oh, ol, zh, zl, sh, sl,
        input logic [PULSE_W-1:0]  pu,
        input logic [REPEAT_W-1:0] rc
    );
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_ONE_HIGH, CFG_W'(oh));
        write_reg(REG_ONE_LOW, CFG_W'(ol));
        write_reg(REG_ZERO_HIGH, CFG_W'(zh));
        write_reg(REG_ZERO_LOW, CFG_W'(zl));
        write_reg(REG_SYNC_HIGH, CFG_W'(sh));
        write_reg(REG_SYNC_LOW, CFG_W'(sl));
        write_reg(REG_PULSE_UNIT, CFG_W'(pu));
        write_reg(REG_REPEAT_COUNT, CFG_W'(rc));
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    function automatic logic [UNIT_W-1:0] random_units();
        return ($urandom_range(0, 4) == 0) ? '0 : UNIT_W'($urandom_range(1, 3));
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            int stall;
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                holds_done++;
            end
            stall = idling ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            results_seen++;
            last_busy = m_tdata[1];
        end
    end

    // Stimulus and verdict.
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = MODE_TICK;
        cfg_we    = 1'b0;
        cfg_addr  = REG_ONE_HIGH;
        cfg_wdata = '0;
        wrap_up   = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Ticks while idle under the reset settings.
        send_word(MODE_TICK, '1, 1'b1);
        send_word(MODE_TICK, '0, 1'b0);

        // Reset unit counts with a short unit and one frame; a second start is ignored.
        load_settings(RST_ONE_HIGH, RST_ONE_LOW, RST_ZERO_HIGH, RST_ZERO_LOW,
                      RST_SYNC_HIGH, RST_SYNC_LOW, 16'd1, 8'd1);
        send_word(MODE_START, '0, 1'b1);
        send_word(MODE_START, '1, 1'b0);
        run_out(1'b1);

        // No repeats: a start sends nothing.
        load_settings(8'd3, 8'd1, 8'd1, 8'd3, 8'd1, 8'd31, 16'd1, 8'd0);
        send_word(MODE_START, 10'h2AA, 1'b1);
        send_tick();
        run_out(1'b0);

        // Every phase empty: the send ends on its first tick.
        load_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd1, 8'd5);
        send_word(MODE_START, '1, 1'b1);
        send_tick();
        send_tick();
        run_out(1'b0);

        // A zero pulse unit empties every phase as well.
        load_settings(8'd3, 8'd1, 8'd1, 8'd3, 8'd1, 8'd31, 16'd0, 8'd3);
        send_word(MODE_START, 10'h155, 1'b0);
        send_tick();
        send_tick();
        run_out(1'b0);

        // Some empty phases mixed in, both power symbols.
        load_settings(8'd1, 8'd0, 8'd0, 8'd2, 8'd0, 8'd1, 16'd1, 8'd2);
        send_word(MODE_START, 10'h2AA, 1'b0);
        run_out(1'b0);
        send_word(MODE_START, 10'h155, 1'b1);
        run_out(1'b0);

        // Widest unit count on the single one bit of the frame.
        load_settings(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd1, 8'd1);
        send_word(MODE_START, 10'h3FF, 1'b1);
        run_out(1'b1);

        // Most repeats of a one-tick frame.
        load_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 16'd1, 8'hFF);
        send_word(MODE_START, 10'h001, 1'b1);
        run_out(1'b1);

        // Random settings, each with a burst of mostly ticks and occasional starts.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_settings(random_units(), random_units(), random_units(), random_units(),
                          random_units(), random_units(), PULSE_W'($urandom_range(1, 2)),
                          REPEAT_W'($urandom_range(0, 2)));
            idling = ($urandom_range(0, 3) != 0);
            if (p == HOLD_PHASE) begin
                idling = 1'b0;
                hold_request = 1'b1;
            end
            repeat (WORDS_PER_PHASE) begin
                if ($urandom_range(0, 59) == 0)
                    wait_for_results();
                if ($urandom_range(0, 11) == 0)
                    send_word(MODE_START, ADDRESS_WIDTH'($urandom_range(0, 1023)),
                              1'($urandom_range(0, 1)));
                else
                    send_tick();
            end
            run_out(1'b0);
        end

        wait_for_results();
        repeat (SETTLE_CYCLES * 2) @(posedge aclk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge aclk);

        $display("Sent %0d words, %0d of them start requests, under %0d register settings.",
                 words_sent, starts_sent, settings_loaded);
        $display("Random gaps on both sides, %0d long output hold-off(s), %0d failures.",
                 holds_done, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Safety net against a hung handshake.
    initial begin
        #(20_000_000);
        $display("Timeout: the run did not finish in time.");
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/trpe_pkg.sv
src/tristate_remote_pulse_encoder_core.sv
tb/trpe_pin_checker.sv
tb/tristate_remote_pulse_encoder_core_tb.sv
